### src/gffrp_pkg.sv
// shared constants, register indexes and state type of the grid first-fit rectangle placer
package gffrp_pkg;

  // default map geometry
  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  // field widths
  localparam int PIX_W  = 13;
  localparam int CELL_W = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_HEIGHT = 3'd5;

  // register reset values
  localparam logic [CELL_W-1:0] GRID_COLS_RST   = 7'd64;
  localparam logic [CELL_W-1:0] GRID_ROWS_RST   = 7'd64;
  localparam logic [CELL_W-1:0] CELL_WIDTH_RST  = 7'd8;
  localparam logic [CELL_W-1:0] CELL_HEIGHT_RST = 7'd8;
  localparam logic [PIX_W-1:0]  AREA_WIDTH_RST  = 13'd512;
  localparam logic [PIX_W-1:0]  AREA_HEIGHT_RST = 13'd512;

  // restoring divider: one quotient bit per cycle
  localparam int DIV_STEPS = 13;
  localparam int DIV_CNT_W = 4;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_BASE,
    ST_MARK,
    ST_ORG,
    ST_CHECK,
    ST_DONE
  } state_t;

endpackage

### src/grid_first_fit_rect_placer_top.sv
// grid first-fit rectangle placer: occupancy bitmap memory, origin scan and window marking
//
//   channel  signals                                          dir
//   ------   -----------------------------------------------  ---
//   in       in_valid in_ready pos_x pos_y rect_width          in
//            rect_height cells_wide cells_high
//   out      out_valid out_ready placed placed_x placed_y      out
//   cfg      cfg_we cfg_index cfg_data                         in
//
// after reset a clearing pass writes all MAX_COLS * MAX_ROWS entries with in_ready low;
//   config writes are taken throughout
// fixed: divide, multiply and base states, one write per window cell, then the output load
// auto: one bounds check per origin; a fitting origin reads one cell per cycle up to the
//   first busy cell; a free window adds one write per cell, then the output load
// one transaction at a time; the done state holds while the output register is still unread
module grid_first_fit_rect_placer_top #(
  parameter int MAX_COLS = gffrp_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gffrp_pkg::MAX_ROWS_DEF
) (
  input  logic clk,
  input  logic rst,

  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [gffrp_pkg::PIX_W-1:0]        pos_x,
  input  logic signed [gffrp_pkg::PIX_W-1:0]        pos_y,
  input  logic        [gffrp_pkg::PIX_W-1:0]        rect_width,
  input  logic        [gffrp_pkg::PIX_W-1:0]        rect_height,
  input  logic        [gffrp_pkg::CELL_W-1:0]       cells_wide,
  input  logic        [gffrp_pkg::CELL_W-1:0]       cells_high,

  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic                                      placed,
  output logic signed [gffrp_pkg::PIX_W-1:0]        placed_x,
  output logic signed [gffrp_pkg::PIX_W-1:0]        placed_y,

  input  logic                                      cfg_we,
  input  logic        [gffrp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic        [gffrp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int PW = gffrp_pkg::PIX_W;
  localparam int CW = gffrp_pkg::CELL_W;
  localparam int MAP_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int COL_W = $clog2(MAX_COLS + 1);
  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  // signed linear cell address, wide enough for negative rows and overruns
  localparam int LIN_W = COL_W + 15;
  // pixel origin of a scanned cell
  localparam int PX_RAW = ((COL_W > ROW_W) ? COL_W : ROW_W) + CW;
  localparam int PX_W = (PX_RAW > PW) ? PX_RAW : PW;
  localparam logic signed [LIN_W-1:0] DEPTH_S = LIN_W'(MAP_DEPTH);

  // ---------------------------------------------------------------- config registers
  logic [CW-1:0] grid_cols, grid_rows, cell_width, cell_height;
  logic [PW-1:0] area_width, area_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols   <= gffrp_pkg::GRID_COLS_RST;
      grid_rows   <= gffrp_pkg::GRID_ROWS_RST;
      cell_width  <= gffrp_pkg::CELL_WIDTH_RST;
      cell_height <= gffrp_pkg::CELL_HEIGHT_RST;
      area_width  <= gffrp_pkg::AREA_WIDTH_RST;
      area_height <= gffrp_pkg::AREA_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gffrp_pkg::CFG_GRID_COLS:   grid_cols   <= cfg_data[CW-1:0];
        gffrp_pkg::CFG_GRID_ROWS:   grid_rows   <= cfg_data[CW-1:0];
        gffrp_pkg::CFG_CELL_WIDTH:  cell_width  <= cfg_data[CW-1:0];
        gffrp_pkg::CFG_CELL_HEIGHT: cell_height <= cfg_data[CW-1:0];
        gffrp_pkg::CFG_AREA_WIDTH:  area_width  <= cfg_data[PW-1:0];
        gffrp_pkg::CFG_AREA_HEIGHT: area_height <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: grid clipped to the map, zero cell size counts as one
  logic [COL_W-1:0] eff_cols;
  logic [ROW_W-1:0] eff_rows;
  logic [CW-1:0]    cwid, chgt;
  logic signed [LIN_W-1:0] stride;
  logic scan_empty;

  assign eff_cols = (int'(grid_cols) > MAX_COLS) ? COL_W'(MAX_COLS) : COL_W'(grid_cols);
  assign eff_rows = (int'(grid_rows) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : ROW_W'(grid_rows);
  assign cwid = (cell_width  == '0) ? CW'(1) : cell_width;
  assign chgt = (cell_height == '0) ? CW'(1) : cell_height;
  assign stride = LIN_W'(eff_cols);
  assign scan_empty = (eff_cols == '0) || (eff_rows == '0);

  // ---------------------------------------------------------------- state
  gffrp_pkg::state_t state, state_next;

  // latched transaction
  logic [PW-1:0] rw_q, rh_q;
  logic [CW-1:0] cw_q, ch_q;
  logic          py_neg;

  // result waiting for the output register
  logic          res_placed;
  logic [PW-1:0] res_x, res_y;

  // divider
  logic [PW-1:0] dvd_x, dvd_y;
  logic [CW-1:0] rem_x, rem_y;
  logic [gffrp_pkg::DIV_CNT_W-1:0] div_cnt;
  logic          div_last;
  logic [CW:0]   sh_x, sh_y;
  logic          ge_x, ge_y;
  logic signed [LIN_W-1:0] qy_l, prod;

  // origin scan
  logic [COL_W-1:0] tx;
  logic [ROW_W-1:0] ty;
  logic [PX_W-1:0]  ox, oy;
  logic signed [LIN_W-1:0] org_addr;
  logic row_end, org_last, fit;

  // window walk
  logic signed [LIN_W-1:0] cur_addr, row_addr, walk_base;
  logic [CW-1:0] c_cnt, r_cnt;
  logic          walk_done, walk_init, walk_step, oob;

  // memory port and read tracking
  logic [ADDR_W-1:0] clr_addr, mem_wa, rd_addr;
  logic              clr_last, mem_we, mem_wd, rdata;
  logic              pend, pend_oob, pend_next, busy_hit, org_step;
  logic              accept, out_load;

  assign accept   = in_valid && in_ready;
  assign div_last = (div_cnt == gffrp_pkg::DIV_CNT_W'(gffrp_pkg::DIV_STEPS - 1));
  assign clr_last = (clr_addr == ADDR_W'(MAP_DEPTH - 1));

  assign sh_x = {rem_x, dvd_x[PW-1]};
  assign sh_y = {rem_y, dvd_y[PW-1]};
  assign ge_x = (sh_x >= {1'b0, cwid});
  assign ge_y = (sh_y >= {1'b0, chgt});
  assign qy_l = py_neg ? -LIN_W'(dvd_y) : LIN_W'(dvd_y);

  assign row_end  = (tx == eff_cols - COL_W'(1));
  assign org_last = row_end && (ty == eff_rows - ROW_W'(1));
  assign fit = (({1'b0, ox} + (PX_W + 1)'(rw_q)) <= (PX_W + 1)'(area_width)) &&
               (({1'b0, oy} + (PX_W + 1)'(rh_q)) <= (PX_W + 1)'(area_height));

  // cells off the map are never written and count as busy in a check
  assign oob      = cur_addr[LIN_W-1] || (cur_addr >= DEPTH_S);
  assign rd_addr  = cur_addr[ADDR_W-1:0];
  assign busy_hit = pend && (pend_oob || rdata);
  assign out_load = (state == gffrp_pkg::ST_DONE) && (!out_valid || out_ready);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      gffrp_pkg::ST_CLEAR: if (clr_last) state_next = gffrp_pkg::ST_IDLE;
      gffrp_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (!pos_x[PW-1])    state_next = gffrp_pkg::ST_DIV;
          else if (scan_empty) state_next = gffrp_pkg::ST_DONE;
          else                 state_next = gffrp_pkg::ST_ORG;
        end
      end
      gffrp_pkg::ST_DIV:  if (div_last) state_next = gffrp_pkg::ST_MUL;
      gffrp_pkg::ST_MUL:  state_next = gffrp_pkg::ST_BASE;
      gffrp_pkg::ST_BASE: state_next = gffrp_pkg::ST_MARK;
      gffrp_pkg::ST_MARK: if (walk_done) state_next = gffrp_pkg::ST_DONE;
      gffrp_pkg::ST_ORG: begin
        if (fit)           state_next = gffrp_pkg::ST_CHECK;
        else if (org_last) state_next = gffrp_pkg::ST_DONE;
      end
      gffrp_pkg::ST_CHECK: begin
        priority if (busy_hit) state_next = org_last ? gffrp_pkg::ST_DONE : gffrp_pkg::ST_ORG;
        else if (walk_done)    state_next = gffrp_pkg::ST_MARK;
      end
      gffrp_pkg::ST_DONE: if (out_load) state_next = gffrp_pkg::ST_IDLE;
      default: state_next = gffrp_pkg::ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------- control outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = rd_addr;
    mem_wd    = 1'b1;
    walk_init = 1'b0;
    walk_base = org_addr;
    walk_step = 1'b0;
    org_step  = 1'b0;
    pend_next = 1'b0;
    unique case (state)
      gffrp_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        mem_wd = 1'b0;
      end
      gffrp_pkg::ST_IDLE: in_ready = 1'b1;
      gffrp_pkg::ST_BASE: begin
        walk_init = 1'b1;
        walk_base = LIN_W'(dvd_x) + prod;
      end
      gffrp_pkg::ST_MARK: begin
        mem_we    = !walk_done && !oob;
        walk_step = 1'b1;
      end
      gffrp_pkg::ST_ORG: begin
        walk_init = fit;
        org_step  = !fit;
      end
      gffrp_pkg::ST_CHECK: begin
        // one read issued per cycle, its data judged the cycle after
        if (busy_hit) begin
          org_step = 1'b1;
        end else if (walk_done) begin
          walk_init = 1'b1;
        end else begin
          walk_step = 1'b1;
          pend_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- occupancy memory
  logic occ_mem [MAP_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ_mem[mem_wa] <= mem_wd;
    end
    rdata <= occ_mem[rd_addr];
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gffrp_pkg::ST_CLEAR;
      clr_addr  <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == gffrp_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      pend <= pend_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    pend_oob <= oob;

    if (accept) begin
      rw_q   <= rect_width;
      rh_q   <= rect_height;
      cw_q   <= cells_wide;
      ch_q   <= cells_high;
      py_neg <= pos_y[PW-1];
      dvd_x  <= pos_x;
      dvd_y  <= pos_y[PW-1] ? -pos_y : pos_y;
      rem_x  <= '0;
      rem_y  <= '0;
      div_cnt <= '0;
      tx <= '0;
      ty <= '0;
      ox <= '0;
      oy <= '0;
      org_addr <= '0;
      // an auto transaction starts as a miss until an origin fits
      if (!pos_x[PW-1]) begin
        res_placed <= 1'b1;
        res_x      <= pos_x;
        res_y      <= pos_y;
      end else begin
        res_placed <= 1'b0;
        res_x      <= '1;
        res_y      <= '1;
      end
    end

    if (state == gffrp_pkg::ST_DIV) begin
      rem_x   <= ge_x ? CW'(sh_x - {1'b0, cwid}) : sh_x[CW-1:0];
      rem_y   <= ge_y ? CW'(sh_y - {1'b0, chgt}) : sh_y[CW-1:0];
      dvd_x   <= {dvd_x[PW-2:0], ge_x};
      dvd_y   <= {dvd_y[PW-2:0], ge_y};
      div_cnt <= div_cnt + gffrp_pkg::DIV_CNT_W'(1);
    end

    if (state == gffrp_pkg::ST_MUL) begin
      prod <= qy_l * stride;
    end

    if (state == gffrp_pkg::ST_CHECK && !busy_hit && walk_done) begin
      res_placed <= 1'b1;
      res_x      <= ox[PW-1:0];
      res_y      <= oy[PW-1:0];
    end

    // next candidate origin in row-major order; linear address just counts up
    if (org_step) begin
      org_addr <= org_addr + LIN_W'(1);
      if (row_end) begin
        tx <= '0;
        ox <= '0;
        ty <= ty + ROW_W'(1);
        oy <= oy + PX_W'(chgt);
      end else begin
        tx <= tx + COL_W'(1);
        ox <= ox + PX_W'(cwid);
      end
    end

    // window walk, wrapping into the next row at the stride
    if (walk_init) begin
      cur_addr  <= walk_base;
      row_addr  <= walk_base;
      c_cnt     <= '0;
      r_cnt     <= '0;
      walk_done <= (cw_q == '0) || (ch_q == '0);
    end else if (walk_step && !walk_done) begin
      if (c_cnt == cw_q - CW'(1)) begin
        c_cnt    <= '0;
        row_addr <= row_addr + stride;
        cur_addr <= row_addr + stride;
        if (r_cnt == ch_q - CW'(1)) begin
          walk_done <= 1'b1;
        end else begin
          r_cnt <= r_cnt + CW'(1);
        end
      end else begin
        c_cnt    <= c_cnt + CW'(1);
        cur_addr <= cur_addr + LIN_W'(1);
      end
    end

    if (out_load) begin
      placed   <= res_placed;
      placed_x <= res_x;
      placed_y <= res_y;
    end
  end

  // ---------------------------------------------------------------- assertions
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while one is in flight");

  a_miss_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !placed |-> (placed_x == '1) && (placed_y == '1))
    else $error("miss result without -1 origin");

  a_no_write_in_check: assert property (@(posedge clk) disable iff (rst)
    state == gffrp_pkg::ST_CHECK |-> !mem_we)
    else $error("map written during a window check");

  a_pend_from_check: assert property (@(posedge clk) disable iff (rst)
    pend |-> $past(state) == gffrp_pkg::ST_CHECK)
    else $error("read data tracked outside a window check");

endmodule

### tb/tb_grid_first_fit_rect_placer_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the grid first-fit rectangle placer and its placement predictor
module tb_grid_first_fit_rect_placer_top;

  // field widths taken from the package
  localparam int PIX_W      = gffrp_pkg::PIX_W;
  localparam int CELL_W     = gffrp_pkg::CELL_W;
  localparam int CFG_IDX_W  = gffrp_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = gffrp_pkg::CFG_DATA_W;

  // map geometry of the instance under test (package defaults)
  localparam int MAP_COLS  = gffrp_pkg::MAX_COLS_DEF;
  localparam int MAP_ROWS  = gffrp_pkg::MAX_ROWS_DEF;
  localparam int MAP_DEPTH = MAP_COLS * MAP_ROWS;

  // run shape
  localparam int RANDOM_ITEMS  = 1930;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 64;
  localparam int CYCLE_LIMIT   = 50_000_000;
  localparam int REPORT_LIMIT  = 10;

  // one placement request as it goes into the block
  typedef struct {
    logic signed [PIX_W-1:0]  pos_x;
    logic signed [PIX_W-1:0]  pos_y;
    logic        [PIX_W-1:0]  rect_width;
    logic        [PIX_W-1:0]  rect_height;
    logic        [CELL_W-1:0] cells_wide;
    logic        [CELL_W-1:0] cells_high;
  } request_t;

  // one placement result as it comes out of the block
  typedef struct {
    logic                    placed;
    logic signed [PIX_W-1:0] placed_x;
    logic signed [PIX_W-1:0] placed_y;
  } placement_t;

  logic clk;
  logic rst;

  logic                     in_valid;
  logic                     in_ready;
  logic signed [PIX_W-1:0]  pos_x;
  logic signed [PIX_W-1:0]  pos_y;
  logic        [PIX_W-1:0]  rect_width;
  logic        [PIX_W-1:0]  rect_height;
  logic        [CELL_W-1:0] cells_wide;
  logic        [CELL_W-1:0] cells_high;

  logic                    out_valid;
  logic                    out_ready;
  logic                    placed;
  logic signed [PIX_W-1:0] placed_x;
  logic signed [PIX_W-1:0] placed_y;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state: occupancy map and a shadow of the register file
  logic              occupied [MAP_DEPTH];
  logic [CELL_W-1:0] grid_cols_q;
  logic [CELL_W-1:0] grid_rows_q;
  logic [CELL_W-1:0] cell_w_q;
  logic [CELL_W-1:0] cell_h_q;
  logic [PIX_W-1:0]  area_w_q;
  logic [PIX_W-1:0]  area_h_q;

  // placements predicted at acceptance, oldest first
  placement_t pending_placements[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int stall_mode     = 0;
  int stall_left     = 0;

  grid_first_fit_rect_placer_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .cells_wide  (cells_wide),
    .cells_high  (cells_high),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .placed      (placed),
    .placed_x    (placed_x),
    .placed_y    (placed_y),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // placement predictor
  // ---------------------------------------------------------------------------

  // columns beyond the map width are folded down to it, for scan and stride alike
  function automatic int eff_stride();
    return (grid_cols_q > MAP_COLS) ? MAP_COLS : int'(grid_cols_q);
  endfunction

  function automatic int eff_rows();
    return (grid_rows_q > MAP_ROWS) ? MAP_ROWS : int'(grid_rows_q);
  endfunction

  // a zero cell size behaves as one pixel
  function automatic int eff_cell_w();
    return (cell_w_q == 0) ? 1 : int'(cell_w_q);
  endfunction

  function automatic int eff_cell_h();
    return (cell_h_q == 0) ? 1 : int'(cell_h_q);
  endfunction

  // any covered cell that is taken or lies off the map blocks the window
  function automatic logic window_blocked(int base, int wc, int hc, int stride);
    int a;
    for (int r = 0; r < hc; r++) begin
      for (int c = 0; c < wc; c++) begin
        a = base + r * stride + c;
        if (a < 0 || a >= MAP_DEPTH) return 1'b1;
        if (occupied[a]) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // mark covered cells, silently skipping addresses off the map
  function automatic void claim_window(int base, int wc, int hc, int stride);
    int a;
    for (int r = 0; r < hc; r++) begin
      for (int c = 0; c < wc; c++) begin
        a = base + r * stride + c;
        if (a >= 0 && a < MAP_DEPTH) occupied[a] = 1'b1;
      end
    end
  endfunction

  // result of one request; updates the occupancy map as the block would
  function automatic placement_t predict_placement(request_t rq);
    int px, py, rw, rh, wc, hc;
    int stride, cwid, chgt, ox, oy, base;
    placement_t res;
    px     = rq.pos_x;
    py     = rq.pos_y;
    rw     = rq.rect_width;
    rh     = rq.rect_height;
    wc     = rq.cells_wide;
    hc     = rq.cells_high;
    stride = eff_stride();
    cwid   = eff_cell_w();
    chgt   = eff_cell_h();
    res.placed   = 1'b0;
    res.placed_x = '1;
    res.placed_y = '1;
    // fixed position: mark without any check, division truncates toward zero
    if (px >= 0) begin
      base = px / cwid + (py / chgt) * stride;
      claim_window(base, wc, hc, stride);
      res.placed   = 1'b1;
      res.placed_x = rq.pos_x;
      res.placed_y = rq.pos_y;
      return res;
    end
    // automatic: first origin in row-major order that is in bounds and free
    for (int ty = 0; ty < eff_rows(); ty++) begin
      for (int tx = 0; tx < stride; tx++) begin
        ox = tx * cwid;
        oy = ty * chgt;
        if (ox + rw <= int'(area_w_q) && oy + rh <= int'(area_h_q)) begin
          base = tx + ty * stride;
          if (!window_blocked(base, wc, hc, stride)) begin
            claim_window(base, wc, hc, stride);
            res.placed   = 1'b1;
            res.placed_x = ox[PIX_W-1:0];
            res.placed_y = oy[PIX_W-1:0];
            return res;
          end
        end
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic request_t request_of(int px, int py, int rw, int rh, int wc, int hc);
    request_t rq;
    rq.pos_x       = px;
    rq.pos_y       = py;
    rq.rect_width  = rw;
    rq.rect_height = rh;
    rq.cells_wide  = wc;
    rq.cells_high  = hc;
    return rq;
  endfunction

  // one transaction on the input channel; called and returns at a falling edge.
  // the sender runs in bursts: at the end of a burst valid drops for a random gap
  task automatic send_request(input request_t rq);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    pos_x       = rq.pos_x;
    pos_y       = rq.pos_y;
    rect_width  = rq.rect_width;
    rect_height = rq.rect_height;
    cells_wide  = rq.cells_wide;
    cells_high  = rq.cells_high;
    in_valid    = 1'b1;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge: predict in acceptance order
    pending_placements.push_back(predict_placement(rq));
    @(negedge clk);
  endtask

  // hold off the sender until every predicted result has been taken
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_placements.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one register write, mirrored into the predictor's shadow copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value[CFG_DATA_W-1:0];
    case (idx)
      gffrp_pkg::CFG_GRID_COLS:   grid_cols_q = value[CELL_W-1:0];
      gffrp_pkg::CFG_GRID_ROWS:   grid_rows_q = value[CELL_W-1:0];
      gffrp_pkg::CFG_CELL_WIDTH:  cell_w_q    = value[CELL_W-1:0];
      gffrp_pkg::CFG_CELL_HEIGHT: cell_h_q    = value[CELL_W-1:0];
      gffrp_pkg::CFG_AREA_WIDTH:  area_w_q    = value[PIX_W-1:0];
      gffrp_pkg::CFG_AREA_HEIGHT: area_h_q    = value[PIX_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // full geometry change, only ever with the block drained
  task automatic set_geometry(input int cols, input int rows, input int cw, input int ch,
                              input int aw, input int ah);
    wait_idle();
    write_reg(gffrp_pkg::CFG_GRID_COLS, cols);
    write_reg(gffrp_pkg::CFG_GRID_ROWS, rows);
    write_reg(gffrp_pkg::CFG_CELL_WIDTH, cw);
    write_reg(gffrp_pkg::CFG_CELL_HEIGHT, ch);
    write_reg(gffrp_pkg::CFG_AREA_WIDTH, aw);
    write_reg(gffrp_pkg::CFG_AREA_HEIGHT, ah);
  endtask

  // random request shaped by the current geometry
  function automatic request_t random_request();
    request_t rq;
    int kind, cwe, che, wc, hc, aw, ah;
    cwe  = eff_cell_w();
    che  = eff_cell_h();
    aw   = (area_w_q > 4096) ? 4096 : int'(area_w_q);
    ah   = (area_h_q > 4096) ? 4096 : int'(area_h_q);
    if (aw < 1) aw = 1;
    if (ah < 1) ah = 1;
    kind = $urandom_range(0, 99);
    rq.pos_y = $urandom_range(0, 8191);
    if (kind < 50) begin
      // well-formed auto request, pixel size rounds up to the cell count
      wc = $urandom_range(1, 3);
      hc = $urandom_range(1, 3);
      rq.pos_x       = -1;
      rq.rect_width  = wc * cwe - $urandom_range(0, cwe - 1);
      rq.rect_height = hc * che - $urandom_range(0, che - 1);
      rq.cells_wide  = wc;
      rq.cells_high  = hc;
    end else if (kind < 60) begin
      // empty window in one direction: takes the first in-bounds origin
      rq.pos_x       = -1;
      rq.rect_width  = $urandom_range(0, aw);
      rq.rect_height = $urandom_range(0, ah);
      if ($urandom_range(0, 1) == 1) begin
        rq.cells_wide = 0;
        rq.cells_high = $urandom_range(0, 8);
      end else begin
        rq.cells_wide = $urandom_range(0, 8);
        rq.cells_high = 0;
      end
    end else if (kind < 66) begin
      // noise: any negative x, sizes unrelated to each other
      rq.pos_x       = -$urandom_range(1, 4096);
      rq.rect_width  = $urandom_range(0, 4096);
      rq.rect_height = $urandom_range(0, 4096);
      rq.cells_wide  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64)
                                                   : $urandom_range(0, 4);
      rq.cells_high  = $urandom_range(0, 2);
    end else begin
      // fixed request, sometimes far out or with a negative y
      rq.pos_x = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                             : $urandom_range(0, aw - 1);
      rq.pos_y = ($urandom_range(0, 9) == 0) ? -$urandom_range(1, 4096)
                                             : $urandom_range(0, ah - 1);
      if ($urandom_range(0, 19) == 0) begin
        wc = $urandom_range(4, 64);
        hc = 1;
      end else begin
        wc = $urandom_range(0, 3);
        hc = $urandom_range(0, 3);
      end
      rq.rect_width  = wc * cwe;
      rq.rect_height = hc * che;
      rq.cells_wide  = wc;
      rq.cells_high  = hc;
    end
    return rq;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset geometry: 64 x 64 cells of 8 x 8 pixels over a 512 x 512 area
  task automatic test_default_geometry();
    send_request(request_of(-1, 0, 8, 8, 1, 1));          // first origin of an empty map
    send_request(request_of(-1, 4095, 16, 16, 2, 2));     // y is ignored on auto
    send_request(request_of(0, 0, 8, 8, 1, 1));           // fixed onto a taken cell, no check
    send_request(request_of(4095, 4095, 8, 8, 1, 1));     // fixed far past the map
    send_request(request_of(-4096, 100, 8, 8, 1, 1));     // most negative x is still auto
    send_request(request_of(-1, 0, 4096, 8, 1, 1));       // wider than the area: miss
    send_request(request_of(-1, 0, 0, 0, 0, 0));          // empty window, zero size
    send_request(request_of(-1, 0, 512, 512, 64, 0));     // full-width rect, empty window
    send_request(request_of(-1, 0, 8, 4096, 0, 64));      // taller than the area: miss
    send_request(request_of(8, -1, 8, 8, 1, 1));          // small negative y truncates to row 0
    send_request(request_of(16, -4096, 8, 8, 2, 2));      // negative linear address, not marked
  endtask

  // zero and oversized grid, zero cell size, narrow area
  task automatic test_degenerate_grid();
    set_geometry(0, 8, 0, 0, 64, 64);
    send_request(request_of(-1, 0, 1, 1, 1, 1));          // zero columns: nothing scanned
    send_request(request_of(5, 3, 2, 2, 2, 2));           // fixed with zero stride
    set_geometry(100, 0, 8, 8, 512, 512);
    send_request(request_of(-1, 0, 8, 8, 1, 1));          // zero rows: miss
    set_geometry(3, 100, 1, 1, 1, 4096);
    send_request(request_of(-1, 0, 1, 1, 1, 1));          // only column 0 in bounds, rows folded
    send_request(request_of(-1, 0, 1, 1, 4, 2));          // window runs past the row end
  endtask

  // cells wider than the map allows in pixels: origins beyond 4095 wrap
  task automatic test_wide_cells();
    set_geometry(64, 1, 127, 64, 8191, 4096);
    send_request(request_of(0, 0, 127, 64, 41, 1));       // fill the head of row 0
    send_request(request_of(-1, 0, 127, 64, 1, 1));       // lands past pixel 4095
    send_request(request_of(4095, 4095, 4096, 4096, 64, 64));
    set_geometry(64, 2, 64, 64, 4096, 4096);
    send_request(request_of(-1, 0, 64, 64, 1, 1));
  endtask

  // random phases: each drains the block, picks a geometry and runs a batch
  task automatic test_random_placement();
    int sent, phase, n, cols, rows, cw, ch, span_w, span_h, aw, ah, row_cap;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      row_cap = 4 + phase / 2;
      if (row_cap > 32) row_cap = 32;
      case ($urandom_range(0, 15))
        0: begin
          cols = 0;
          rows = $urandom_range(1, 12);
        end
        1: begin
          cols = $urandom_range(1, 12);
          rows = 0;
        end
        2: begin
          cols = $urandom_range(64, 127);
          rows = $urandom_range(1, 4);
        end
        3: begin
          cols = $urandom_range(1, 6);
          rows = $urandom_range(64, 127);
        end
        default: begin
          cols = $urandom_range(1, 12);
          rows = $urandom_range(1, row_cap);
        end
      endcase
      cw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 16);
      ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 16);
      // area roughly covers the grid, a little short so the bounds check bites
      span_w = ((cols > MAP_COLS) ? MAP_COLS : cols) * ((cw == 0) ? 1 : cw);
      span_h = ((rows > MAP_ROWS) ? MAP_ROWS : rows) * ((ch == 0) ? 1 : ch);
      aw = span_w - $urandom_range(0, span_w / 4);
      ah = span_h - $urandom_range(0, span_h / 4);
      if (aw < 1 || $urandom_range(0, 3) == 0) aw = $urandom_range(1, 4096);
      if (ah < 1 || $urandom_range(0, 3) == 0) ah = $urandom_range(1, 4096);
      set_geometry(cols, rows, cw, ch, aw, ah);
      n = $urandom_range(25, 60);
      repeat (n) begin
        send_request(random_request());
        sent++;
      end
      phase++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall pattern of its own, independent of the sender
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(4, 64);
      end
      stall_left--;
      case (stall_mode)
        0:       out_ready = 1'b1;                          // always ready
        1:       out_ready = $urandom_range(0, 1);          // coin flip
        2:       out_ready = ($urandom_range(0, 3) == 0);   // mostly stalled
        default: out_ready = 1'b0;                          // hard stall
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every output transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_placements
    placement_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_placements.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unrequested result: placed=%0b x=%0d y=%0d", placed, placed_x, placed_y);
      end else begin
        want = pending_placements.pop_front();
        if (placed !== want.placed || placed_x !== want.placed_x ||
            placed_y !== want.placed_y) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"placement differs: expected placed=%0b x=%0d y=%0d,",
                      " got placed=%0b x=%0d y=%0d"},
                     want.placed, want.placed_x, want.placed_y, placed, placed_x, placed_y);
        end
      end
    end
  end

  // watchdog: a hang ends the run as a failure
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("grid_first_fit_rect_placer_top: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    pos_x       = '0;
    pos_y       = '0;
    rect_width  = '0;
    rect_height = '0;
    cells_wide  = '0;
    cells_high  = '0;
    cfg_we      = 1'b0;
    cfg_index   = gffrp_pkg::CFG_GRID_COLS;
    cfg_data    = '0;
    foreach (occupied[i]) occupied[i] = 1'b0;
    grid_cols_q = gffrp_pkg::GRID_COLS_RST;
    grid_rows_q = gffrp_pkg::GRID_ROWS_RST;
    cell_w_q    = gffrp_pkg::CELL_WIDTH_RST;
    cell_h_q    = gffrp_pkg::CELL_HEIGHT_RST;
    area_w_q    = gffrp_pkg::AREA_WIDTH_RST;
    area_h_q    = gffrp_pkg::AREA_HEIGHT_RST;

    // reset, released at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // the block clears its map first; send_request waits on in_ready through it
    test_default_geometry();
    test_degenerate_grid();
    test_wide_cells();
    test_random_placement();

    // drain, then give stray results a chance to show up
    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_placements.size() == 0) begin
      $display("grid_first_fit_rect_placer_top: match");
    end else begin
      $display("grid_first_fit_rect_placer_top: mismatch");
    end
    $finish;
  end

endmodule
